>>> hdl/ecm_pkg.sv
// shared constants and types for the two-level exclusive cache model
`default_nettype none
package ecm_pkg;

  // default sizing of the line stores
  localparam int L1_MAX_SETS_DEF  = 256;
  localparam int L1_MAX_WAYS_DEF  = 8;
  localparam int L2_MAX_SETS_DEF  = 1024;
  localparam int L2_MAX_WAYS_DEF  = 16;
  localparam int ADDRESS_BITS_DEF = 48;

  // stamp counter and offset limit
  localparam int STAMP_W      = 32;
  localparam int OFFSET_LIMIT = 12;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OFFSET_BITS = 3'd0,
    CFG_L1_SET_BITS = 3'd1,
    CFG_L1_WAYS     = 3'd2,
    CFG_L1_USE_LRU  = 3'd3,
    CFG_L2_SET_BITS = 3'd4,
    CFG_L2_WAYS     = 3'd5,
    CFG_L2_USE_LRU  = 3'd6
  } cfg_idx_e;

  // register reset values
  localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [3:0] L1_SET_BITS_RST = 4'd0;
  localparam logic [3:0] L1_WAYS_RST     = 4'd1;
  localparam logic       L1_USE_LRU_RST  = 1'b1;
  localparam logic [3:0] L2_SET_BITS_RST = 4'd0;
  localparam logic [4:0] L2_WAYS_RST     = 5'd1;
  localparam logic       L2_USE_LRU_RST  = 1'b1;

endpackage
`default_nettype wire

>>> hdl/ecm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module ecm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> hdl/two_level_exclusive_cache_model.sv
// top level of the two-level exclusive cache model
// After reset the block sweeps both line stores to clear valid bits and stamps, one entry
// per cycle over max(L1_MAX_SETS*L1_MAX_WAYS, L2_MAX_SETS*L2_MAX_WAYS) entries (16384 with
// the defaults); no access is taken meanwhile, configuration writes are. Each access then
// runs up to four set scans through one shared tag/stamp compare unit: L1 probe, L2 probe,
// and on an L1 miss an L1 fill scan and, if L1 evicts, an L2 fill scan. A scan has a setup
// step, a ram read and a compare for each way, and a write-back step. One access is in
// flight at a time; a finished word waits in the output register while the next access
// is accepted.
`default_nettype none
module two_level_exclusive_cache_model import ecm_pkg::*; #(
  parameter int L1_MAX_SETS  = L1_MAX_SETS_DEF,
  parameter int L1_MAX_WAYS  = L1_MAX_WAYS_DEF,
  parameter int L2_MAX_SETS  = L2_MAX_SETS_DEF,
  parameter int L2_MAX_WAYS  = L2_MAX_WAYS_DEF,
  parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    mode_i,
  input  wire logic [ADDRESS_BITS-1:0] byte_address_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic                         l1_hit_o,
  output logic                         l2_hit_o,
  output logic                         memory_read_o,
  output logic                         memory_write_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int AW        = ADDRESS_BITS;
  localparam int EW        = 1 + STAMP_W + AW;
  localparam int L1_DEPTH  = L1_MAX_SETS * L1_MAX_WAYS;
  localparam int L2_DEPTH  = L2_MAX_SETS * L2_MAX_WAYS;
  localparam int IW1       = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
  localparam int IW2       = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;
  localparam int CLR_DEPTH = (L1_DEPTH > L2_DEPTH) ? L1_DEPTH : L2_DEPTH;
  localparam int CW        = $clog2(CLR_DEPTH + 1);
  localparam int MAXW      = (L1_MAX_WAYS > L2_MAX_WAYS) ? L1_MAX_WAYS : L2_MAX_WAYS;
  localparam int WC        = $clog2(MAXW + 1);
  localparam int L1_SBM    = $clog2(L1_MAX_SETS + 1) - 1;
  localparam int L2_SBM    = $clog2(L2_MAX_SETS + 1) - 1;
  localparam int SETW      = 16;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_SETUP, ST_RD, ST_EV, ST_UPD, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    PH_L1_PROBE, PH_L2_PROBE, PH_L1_FILL, PH_L2_FILL
  } phase_e;

  state_e state_q;
  phase_e phase_q;

  // configuration registers
  logic [3:0] off_q, l1sb_q, l2sb_q, l1w_q;
  logic [4:0] l2w_q;
  logic       l1lru_q, l2lru_q;

  // access and scan registers
  logic [CW-1:0]      clr_q;
  logic               mode_q;
  logic [AW-1:0]      addr_q, key_q, hmask_q;
  logic [SETW-1:0]    set_q;
  logic [WC-1:0]      w_q, hitw_q, invw_q, minw_q;
  logic               hit_q, inv_q, h1_q, h2_q;
  logic [AW-1:0]      hitaddr_q, minaddr_q;
  logic [STAMP_W-1:0] hitstamp_q, minstamp_q, ctr_q;
  logic               out_valid_q, o_l1_q, o_l2_q, o_mr_q, o_mw_q;

  // effective configuration
  logic [3:0]    off_eff, sb1, sb2, sb_cur;
  logic [WC-1:0] ways1, ways2, ways_cur;
  logic          lvl1;

  always_comb begin
    off_eff = (32'(off_q) > OFFSET_LIMIT) ? 4'(OFFSET_LIMIT) : off_q;
    sb1     = (32'(l1sb_q) > L1_SBM) ? 4'(L1_SBM) : l1sb_q;
    sb2     = (32'(l2sb_q) > L2_SBM) ? 4'(L2_SBM) : l2sb_q;
    if (l1w_q == 4'd0) begin
      ways1 = WC'(1);
    end else if (32'(l1w_q) > L1_MAX_WAYS) begin
      ways1 = WC'(L1_MAX_WAYS);
    end else begin
      ways1 = WC'(l1w_q);
    end
    if (l2w_q == 5'd0) begin
      ways2 = WC'(1);
    end else if (32'(l2w_q) > L2_MAX_WAYS) begin
      ways2 = WC'(L2_MAX_WAYS);
    end else begin
      ways2 = WC'(l2w_q);
    end
    lvl1     = (phase_q == PH_L1_PROBE) || (phase_q == PH_L1_FILL);
    sb_cur   = lvl1 ? sb1 : sb2;
    ways_cur = lvl1 ? ways1 : ways2;
  end

  // way picked for the update: hit way on a probe, victim way on a fill
  logic [WC-1:0] way_sel, upd_way;
  logic          is_probe;

  always_comb begin
    is_probe = (phase_q == PH_L1_PROBE) || (phase_q == PH_L2_PROBE);
    if (is_probe) begin
      upd_way = hitw_q;
    end else begin
      upd_way = inv_q ? invw_q : minw_q;
    end
    way_sel = (state_q == ST_UPD) ? upd_way : w_q;
  end

  // ram index of the selected way in the current set
  logic [IW1-1:0] idx1;
  logic [IW2-1:0] idx2;

  assign idx1 = IW1'(32'(set_q) * 32'(L1_MAX_WAYS) + 32'(way_sel));
  assign idx2 = IW2'(32'(set_q) * 32'(L2_MAX_WAYS) + 32'(way_sel));

  // ram ports
  logic           we1, we2;
  logic [IW1-1:0] wa1;
  logic [IW2-1:0] wa2;
  logic [EW-1:0]  wd, rd1, rd2, rd;

  always_comb begin
    we1 = 1'b0;
    we2 = 1'b0;
    wa1 = idx1;
    wa2 = idx2;
    wd  = '0;
    case (state_q)
      ST_CLEAR: begin
        we1 = (32'(clr_q) < L1_DEPTH);
        we2 = (32'(clr_q) < L2_DEPTH);
        wa1 = IW1'(clr_q);
        wa2 = IW2'(clr_q);
      end
      ST_UPD: begin
        case (phase_q)
          PH_L1_PROBE: begin
            we1 = hit_q && l1lru_q;
            wd  = {1'b1, ctr_q, hitaddr_q};
          end
          PH_L2_PROBE: begin
            we2 = hit_q;
            wd  = {1'b0, (l2lru_q ? ctr_q : hitstamp_q), hitaddr_q};
          end
          PH_L1_FILL: begin
            we1 = 1'b1;
            wd  = {1'b1, ctr_q, key_q};
          end
          PH_L2_FILL: begin
            we2 = 1'b1;
            wd  = {1'b1, ctr_q, key_q};
          end
          default: begin
            we1 = 1'b0;
          end
        endcase
      end
      default: begin
        we1 = 1'b0;
      end
    endcase
  end

  ecm_ram #(.WIDTH(EW), .DEPTH(L1_DEPTH)) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (wa1),
    .wdata_i (wd),
    .raddr_i (idx1),
    .rdata_o (rd1)
  );

  ecm_ram #(.WIDTH(EW), .DEPTH(L2_DEPTH)) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (wa2),
    .wdata_i (wd),
    .raddr_i (idx2),
    .rdata_o (rd2)
  );

  // shared compare unit on the line just read
  logic               e_valid, e_match, e_less;
  logic [STAMP_W-1:0] e_stamp;
  logic [AW-1:0]      e_addr;

  always_comb begin
    rd      = lvl1 ? rd1 : rd2;
    e_valid = rd[EW-1];
    e_stamp = rd[EW-2:AW];
    e_addr  = rd[AW-1:0];
    e_match = e_valid && (((e_addr ^ key_q) & hmask_q) == '0);
    e_less  = (w_q == '0) || (e_stamp < minstamp_q);
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign cfg_ready_o    = 1'b1;
  assign out_valid_o    = out_valid_q;
  assign l1_hit_o       = o_l1_q;
  assign l2_hit_o       = o_l2_q;
  assign memory_read_o  = o_mr_q;
  assign memory_write_o = o_mw_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= OFFSET_BITS_RST;
      l1sb_q  <= L1_SET_BITS_RST;
      l1w_q   <= L1_WAYS_RST;
      l1lru_q <= L1_USE_LRU_RST;
      l2sb_q  <= L2_SET_BITS_RST;
      l2w_q   <= L2_WAYS_RST;
      l2lru_q <= L2_USE_LRU_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OFFSET_BITS: off_q   <= cfg_data_i[3:0];
        CFG_L1_SET_BITS: l1sb_q  <= cfg_data_i[3:0];
        CFG_L1_WAYS:     l1w_q   <= cfg_data_i[3:0];
        CFG_L1_USE_LRU:  l1lru_q <= cfg_data_i[0];
        CFG_L2_SET_BITS: l2sb_q  <= cfg_data_i[3:0];
        CFG_L2_WAYS:     l2w_q   <= cfg_data_i;
        CFG_L2_USE_LRU:  l2lru_q <= cfg_data_i[0];
        default: begin
          off_q <= off_q;
        end
      endcase
    end
  end

  // sequencer, scan accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      phase_q     <= PH_L1_PROBE;
      clr_q       <= '0;
      ctr_q       <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      inv_q       <= 1'b0;
      h1_q        <= 1'b0;
      h2_q        <= 1'b0;
      w_q         <= '0;
    end else begin
      // result word taken, unless a new one is loaded below
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // clearing sweep over both line stores
        ST_CLEAR: begin
          clr_q <= clr_q + CW'(1);
          if (32'(clr_q) == CLR_DEPTH - 1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_i;
            addr_q  <= byte_address_i;
            key_q   <= byte_address_i;
            phase_q <= PH_L1_PROBE;
            state_q <= ST_SETUP;
          end
        end
        // set index and tag mask for the key of this scan
        ST_SETUP: begin
          set_q   <= SETW'(key_q >> off_eff) & SETW'((17'd1 << sb_cur) - 17'd1);
          hmask_q <= {AW{1'b1}} << (5'(off_eff) + 5'(sb_cur));
          hit_q   <= 1'b0;
          inv_q   <= 1'b0;
          w_q     <= '0;
          state_q <= ST_RD;
        end
        ST_RD: begin
          state_q <= ST_EV;
        end
        // compare one way
        ST_EV: begin
          if (e_match && !hit_q) begin
            hit_q      <= 1'b1;
            hitw_q     <= w_q;
            hitaddr_q  <= e_addr;
            hitstamp_q <= e_stamp;
          end
          if (!e_valid && !inv_q) begin
            inv_q  <= 1'b1;
            invw_q <= w_q;
          end
          if (e_less) begin
            minw_q     <= w_q;
            minstamp_q <= e_stamp;
            minaddr_q  <= e_addr;
          end
          w_q <= w_q + WC'(1);
          if (w_q + WC'(1) == ways_cur) begin
            state_q <= ST_UPD;
          end else begin
            state_q <= ST_RD;
          end
        end
        // write back and choose the next scan
        ST_UPD: begin
          case (phase_q)
            PH_L1_PROBE: begin
              h1_q <= hit_q;
              if (hit_q && l1lru_q) begin
                ctr_q <= ctr_q + 32'd1;
              end
              key_q   <= addr_q;
              phase_q <= PH_L2_PROBE;
              state_q <= ST_SETUP;
            end
            PH_L2_PROBE: begin
              h2_q <= hit_q;
              if (hit_q && l2lru_q) begin
                ctr_q <= ctr_q + 32'd1;
              end
              if (h1_q) begin
                state_q <= ST_FIN;
              end else begin
                key_q   <= hit_q ? hitaddr_q : addr_q;
                phase_q <= PH_L1_FILL;
                state_q <= ST_SETUP;
              end
            end
            PH_L1_FILL: begin
              ctr_q <= ctr_q + 32'd1;
              if (!inv_q) begin
                key_q   <= minaddr_q;
                phase_q <= PH_L2_FILL;
                state_q <= ST_SETUP;
              end else begin
                state_q <= ST_FIN;
              end
            end
            PH_L2_FILL: begin
              ctr_q   <= ctr_q + 32'd1;
              state_q <= ST_FIN;
            end
            default: begin
              state_q <= ST_FIN;
            end
          endcase
        end
        // hand the result word to the output register
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            o_l1_q      <= h1_q;
            o_l2_q      <= !h1_q && h2_q;
            o_mr_q      <= !h1_q && !h2_q;
            o_mw_q      <= mode_q;
            state_q     <= ST_IDLE;
          end else begin
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ecm_chk.sv
// port-level checker for the cache model, bound to the top level
`default_nettype none
module ecm_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_o,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire logic l1_hit_o,
  input wire logic l2_hit_o,
  input wire logic memory_read_o,
  input wire logic memory_write_o
);

  // one access at a time: no word taken right after one is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted on back-to-back cycles");

  // exactly one of l1 hit, l2 hit and memory read per result
  a_outcome_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot({l1_hit_o, l2_hit_o, memory_read_o}))
    else $error("result outcome flags not one-hot");

  // a stalled result word stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      ($stable(l1_hit_o) && $stable(l2_hit_o) && $stable(memory_read_o) &&
       $stable(memory_write_o)))
    else $error("result word changed while stalled");

endmodule

bind two_level_exclusive_cache_model ecm_chk u_ecm_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .l1_hit_o       (l1_hit_o),
  .l2_hit_o       (l2_hit_o),
  .memory_read_o  (memory_read_o),
  .memory_write_o (memory_write_o)
);
`default_nettype wire

>>> dv/tb_two_level_exclusive_cache_model.sv
// testbench for the two-level exclusive cache model with scoreboard and random traffic
`timescale 1ns / 1ps
module tb_two_level_exclusive_cache_model;
  import ecm_pkg::*;

  typedef struct packed {
    bit l1_hit;
    bit l2_hit;
    bit memory_read;
    bit memory_write;
  } access_word_t;

  // predicts hit and memory flags of each access and checks returned words
  class cache_scoreboard;
    bit [47:0]    line_addr  [2][16384];
    bit           line_valid [2][16384];
    bit [31:0]    line_stamp [2][16384];
    bit [31:0]    stamp_ctr;
    bit [4:0]     regs [7];
    access_word_t pending [$];
    int           errors;

    function new();
      regs[CFG_OFFSET_BITS] = OFFSET_BITS_RST;
      regs[CFG_L1_SET_BITS] = L1_SET_BITS_RST;
      regs[CFG_L1_WAYS]     = L1_WAYS_RST;
      regs[CFG_L1_USE_LRU]  = L1_USE_LRU_RST;
      regs[CFG_L2_SET_BITS] = L2_SET_BITS_RST;
      regs[CFG_L2_WAYS]     = L2_WAYS_RST;
      regs[CFG_L2_USE_LRU]  = L2_USE_LRU_RST;
    endfunction

    function void write_reg(cfg_idx_e idx, bit [4:0] value);
      case (idx)
        CFG_L1_USE_LRU, CFG_L2_USE_LRU: regs[idx] = value & 5'd1;
        CFG_L2_WAYS: regs[idx] = value;
        default: regs[idx] = value & 5'd15;
      endcase
    endfunction

    // effective geometry of one level
    function int level_ways(int lv);
      int w, mx;
      w = lv ? regs[CFG_L2_WAYS] : regs[CFG_L1_WAYS];
      mx = lv ? L2_MAX_WAYS_DEF : L1_MAX_WAYS_DEF;
      if (w < 1) return 1;
      if (w > mx) return mx;
      return w;
    endfunction

    function int level_set_bits(int lv);
      int b, mx;
      b = lv ? regs[CFG_L2_SET_BITS] : regs[CFG_L1_SET_BITS];
      mx = lv ? L2_MAX_SETS_DEF : L1_MAX_SETS_DEF;
      while (b > 0 && (1 << b) > mx) b--;
      return b;
    endfunction

    function int set_base(int lv, bit [47:0] a, int off);
      int sb;
      sb = level_set_bits(lv);
      return int'((a >> off) & ((48'd1 << sb) - 1)) * (lv ? L2_MAX_WAYS_DEF : L1_MAX_WAYS_DEF);
    endfunction

    function bit lookup(int lv, bit [47:0] a, int off, bit take, output bit [47:0] found);
      int sh, base;
      bit lru;
      sh = off + level_set_bits(lv);
      base = set_base(lv, a, off);
      lru = lv ? regs[CFG_L2_USE_LRU][0] : regs[CFG_L1_USE_LRU][0];
      found = '0;
      for (int w = 0; w < level_ways(lv); w++) begin
        if (line_valid[lv][base+w] && (line_addr[lv][base+w] >> sh) == (a >> sh)) begin
          found = line_addr[lv][base+w];
          if (lru) line_stamp[lv][base+w] = stamp_ctr++;
          if (take) line_valid[lv][base+w] = 1'b0;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // place a line, first free way else oldest stamp; returns 1 when a line was evicted
    function bit fill(int lv, bit [47:0] a, int off, output bit [47:0] victim);
      int base, pick;
      bit full;
      base = set_base(lv, a, off);
      pick = base;
      full = 1'b1;
      victim = '0;
      for (int w = 0; w < level_ways(lv); w++) begin
        if (!line_valid[lv][base+w]) begin
          pick = base + w;
          full = 1'b0;
          break;
        end
        if (line_stamp[lv][base+w] < line_stamp[lv][pick]) pick = base + w;
      end
      if (full) victim = line_addr[lv][pick];
      line_addr[lv][pick] = a;
      line_valid[lv][pick] = 1'b1;
      line_stamp[lv][pick] = stamp_ctr++;
      return full;
    endfunction

    function void note_access(bit mode, bit [47:0] a);
      int off;
      bit h1, h2;
      bit [47:0] seen, moved, vic, drop;
      access_word_t r;
      off = regs[CFG_OFFSET_BITS];
      if (off > OFFSET_LIMIT) off = OFFSET_LIMIT;
      h1 = lookup(0, a, off, 1'b0, seen);
      h2 = lookup(1, a, off, 1'b1, moved);
      if (!h1) begin
        if (fill(0, h2 ? moved : a, off, vic)) void'(fill(1, vic, off, drop));
      end
      r.l1_hit = h1;
      r.l2_hit = !h1 && h2;
      r.memory_read = !h1 && !h2;
      r.memory_write = mode;
      pending.push_back(r);
    endfunction

    function void check_word(access_word_t got);
      access_word_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %b", got);
        return;
      end
      want = pending.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected l1 %b l2 %b mrd %b mwr %b, got l1 %b l2 %b mrd %b mwr %b",
                   want.l1_hit, want.l2_hit, want.memory_read, want.memory_write,
                   got.l1_hit, got.l2_hit, got.memory_read, got.memory_write);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o, mode_i;
  logic [47:0] byte_address_i;
  logic        out_valid_o, out_ready_i;
  logic        l1_hit_o, l2_hit_o, memory_read_o, memory_write_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  cache_scoreboard sb = new();
  bit        no_idle;
  bit        stall_request;
  int        quiet_cycles;
  bit [47:0] addr_pool [24];

  two_level_exclusive_cache_model DUT (.*);

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: random idling plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  // check returned words, sampled mid-cycle
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_word('{l1_hit_o, l2_hit_o, memory_read_o, memory_write_o});
  end

  // watchdog on cycles without any accepted word
  always @(negedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles > 100000) begin
      $display("** two_level_exclusive_cache_model: FAILED **");
      $finish;
    end
  end

  task automatic send_access(bit mode, bit [47:0] a);
    int gap;
    @(posedge clk_i);
    if (!no_idle && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= mode;
    byte_address_i <= a;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    sb.note_access(mode, a);
  endtask

  task automatic write_cfg(cfg_idx_e idx, bit [4:0] value);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    forever begin
      @(negedge clk_i);
      if (cfg_ready_o) break;
      @(posedge clk_i);
    end
    sb.write_reg(idx, value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for the block to drain, then load a full setting
  task automatic set_geometry(bit [4:0] off, bit [4:0] s1, bit [4:0] w1, bit [4:0] r1,
                              bit [4:0] s2, bit [4:0] w2, bit [4:0] r2);
    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (120) @(posedge clk_i);
    write_cfg(CFG_OFFSET_BITS, off);
    write_cfg(CFG_L1_SET_BITS, s1);
    write_cfg(CFG_L1_WAYS, w1);
    write_cfg(CFG_L1_USE_LRU, r1);
    write_cfg(CFG_L2_SET_BITS, s2);
    write_cfg(CFG_L2_WAYS, w2);
    write_cfg(CFG_L2_USE_LRU, r2);
  endtask

  // mostly reused blocks so that lines hit and get evicted, some fully random
  task automatic random_accesses(int count);
    bit [47:0] a;
    foreach (addr_pool[i]) addr_pool[i] = 48'({$urandom, $urandom});
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85)
        a = addr_pool[$urandom_range(0, 7 + $urandom_range(0, 16))] ^
            48'($urandom_range(0, 255));
      else
        a = 48'({$urandom, $urandom});
      send_access(1'($urandom_range(0, 1)), a);
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    mode_i = 1'b0;
    byte_address_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_OFFSET_BITS;
    cfg_data_i = '0;
    no_idle = 1'b0;
    stall_request = 1'b0;
    quiet_cycles = 0;
    @(posedge rst_ni);

    // directed: one-way levels, swaps between L1 and L2, address extremes
    send_access(1'b0, 48'h0);
    send_access(1'b1, 48'h0);
    send_access(1'b0, 48'hFFFF_FFFF_FFFF);
    send_access(1'b1, 48'h0000_0000_003F);
    send_access(1'b0, 48'hFFFF_FFFF_FFC0);
    send_access(1'b1, 48'h8000_0000_0000);
    send_access(1'b0, 48'h0);
    send_access(1'b0, 48'hFFFF_FFFF_FFFF);
    send_access(1'b1, 48'h5555_5555_5555);
    send_access(1'b1, 48'hAAAA_AAAA_AAAA);
    send_access(1'b0, 48'h5555_5555_5540);
    send_access(1'b0, 48'h8000_0000_0000);
    random_accesses(140);

    // fully associative, widest ways, with a long receiver hold-off
    set_geometry(5'd0, 5'd0, 5'd8, 5'd1, 5'd0, 5'd16, 5'd1);
    stall_request = 1'b1;
    random_accesses(155);
    // most sets, fifo replacement
    set_geometry(5'd12, 5'd8, 5'd1, 5'd0, 5'd10, 5'd16, 5'd0);
    random_accesses(155);
    // out-of-range values that the block clamps
    set_geometry(5'd15, 5'd15, 5'd0, 5'd1, 5'd15, 5'd31, 5'd0);
    random_accesses(155);
    // ways that are not a power of two, no idling on either side
    no_idle = 1'b1;
    set_geometry(5'd4, 5'd2, 5'd3, 5'd0, 5'd3, 5'd5, 5'd1);
    random_accesses(155);
    no_idle = 1'b0;
    // smaller blocks than before, so stale copies linger across levels
    set_geometry(5'd2, 5'd1, 5'd4, 5'd1, 5'd2, 5'd2, 5'd1);
    random_accesses(155);
    for (int p = 0; p < 4; p++) begin
      set_geometry(5'($urandom_range(0, 15)), 5'($urandom_range(0, 15)),
                   5'($urandom_range(0, 15)), 5'($urandom_range(0, 1)),
                   5'($urandom_range(0, 15)), 5'($urandom_range(0, 31)),
                   5'($urandom_range(0, 1)));
      random_accesses(155);
    end

    @(posedge clk_i);
    in_valid_i <= 1'b0;
    wait (sb.pending.size() == 0);
    repeat (120) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** two_level_exclusive_cache_model: PASSED **");
    end else begin
      $display("** two_level_exclusive_cache_model: FAILED **");
    end
    $finish;
  end

endmodule
